FILE: hdl/mfu_page_replacement_core_defines.svh
// Assertion macros shared by the core.
`ifndef MFU_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define MFU_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MFU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfu assertion failed");

// Next-cycle implication, disabled while in reset.
`define MFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfu assertion failed");

`endif

FILE: hdl/mfu_pkg.sv
package mfu_pkg;

    localparam int PAGE_IN_W  = 16;
    localparam int SLOT_W     = 4;
    localparam int EVICT_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int TOTAL_W    = 32;
    localparam int FIU_W      = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;

    localparam logic [FIU_W-1:0]   FIU_RESET = 5'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // tuser bit positions of the result item
    localparam int USER_HIT   = 0;
    localparam int USER_EVICT = 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

endpackage

FILE: hdl/mfu_page_replacement_core.sv
// MFU page replacement core.
// s_* : one page reference per item, s_tdata[15:0] = page_number.
// m_* : one result per item. m_tuser = {evicted_valid, was_hit};
//       m_tdata = {pad, miss_total, hit_total, evicted_page, frame_slot}.
// cfg_*: write of frames_in_use, taken at any time the core is idle.
// Frame pages and use counts live in one synchronous RAM, read one frame per
// cycle; valid bits are flops. An item runs from accept through one RAM read
// per active frame, the RAM read latency and a write-back, then returns to
// idle; the next item is not accepted until then. The result is loaded into
// the output register at the write-back.
// The RAM read port and the single scan counter set the pace of the scan.
// Reset empties every frame, zeroes the totals and sets frames_in_use to 4.
// The result sits in an output register; the next item is accepted while it
// waits, and its write-back stalls until the register has been taken.
// A frames_in_use of 0 acts as 1, above MAX_FRAMES acts as MAX_FRAMES.
`include "mfu_page_replacement_core_defines.svh"

module mfu_page_replacement_core #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mfu_pkg::FIU_W-1:0]        cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mfu_pkg::IN_DATA_W-1:0]    s_tdata,   // [15:0] page_number
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] frame_slot, [19:4] evicted_page, [51:20] hit_total, [83:52] miss_total
    output logic [mfu_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [mfu_pkg::OUT_USER_W-1:0]   m_tuser    // [0] was_hit, [1] evicted_valid
);
    import mfu_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CNT_W > FIU_W) ? CNT_W : FIU_W;
    localparam int MEM_W = PAGE_BITS + COUNT_W;
    localparam int PAD_W = OUT_DATA_W - SLOT_W - EVICT_W - 2 * TOTAL_W;

    state_t state_reg, state_next;

    logic [FIU_W-1:0]     fiu_reg;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [MAX_FRAMES-1:0] valid_reg;

    logic                 hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic                 empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]     empty_idx_reg, empty_idx_next;
    logic [COUNT_W-1:0]   best_cnt_reg, best_cnt_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [PAGE_BITS-1:0] best_page_reg, best_page_next;

    logic [TOTAL_W-1:0]   hit_total_reg, miss_total_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [OUT_USER_W-1:0]   m_tuser_reg;

    logic [MEM_W-1:0]     mem [MAX_FRAMES];
    logic [MEM_W-1:0]     rd_data_reg;
    logic                 rd_en;
    logic                 mem_we;
    logic [MEM_W-1:0]     wr_data;
    logic [IDX_W-1:0]     slot;

    logic [PAGE_BITS-1:0] rd_page;
    logic [COUNT_W-1:0]   rd_cnt;
    logic                 rd_valid;
    logic                 last_cmp;
    logic [CMP_W-1:0]     fiu_ext;
    logic                 in_accept;
    logic                 out_free;
    logic                 is_hit;
    logic                 is_evict;
    logic [COUNT_W-1:0]   new_cnt;
    logic [PAGE_BITS-1:0] in_page;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign in_page = PAGE_BITS'(s_tdata[PAGE_IN_W-1:0]);

    // clamp the active frame count
    assign fiu_ext = CMP_W'(fiu_reg);
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_next = CNT_W'(1);
        end
        else if (fiu_ext > CMP_W'(MAX_FRAMES))
        begin
            n_next = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_next = CNT_W'(fiu_ext);
        end
    end

    // frame RAM: {page, use count}
    assign rd_en = (state_reg == ST_SCAN) && (issue_cnt_reg < n_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    assign rd_page  = rd_data_reg[MEM_W-1:COUNT_W];
    assign rd_cnt   = rd_data_reg[COUNT_W-1:0];
    assign rd_valid = valid_reg[cmp_idx_reg];
    assign last_cmp = cmp_vld_reg && (CNT_W'(cmp_idx_reg) == (n_reg - CNT_W'(1)));

    // scan trackers: first valid match, first empty frame, highest count
    always_comb
    begin
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_cnt_next     = hit_cnt_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        best_cnt_next    = best_cnt_reg;
        best_idx_next    = best_idx_reg;
        best_page_next   = best_page_reg;
        if (cmp_vld_reg)
        begin
            if (rd_valid && (rd_page == page_reg) && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_idx_next   = cmp_idx_reg;
                hit_cnt_next   = rd_cnt;
            end
            if (!rd_valid && !empty_found_reg)
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = cmp_idx_reg;
            end
            // only consulted when every active frame is valid
            if ((cmp_idx_reg == '0) || (rd_cnt > best_cnt_reg))
            begin
                best_cnt_next  = rd_cnt;
                best_idx_next  = cmp_idx_reg;
                best_page_next = rd_page;
            end
        end
    end

    assign is_hit   = hit_found_reg;
    assign is_evict = !hit_found_reg && !empty_found_reg;

    always_comb
    begin
        if (hit_found_reg)
        begin
            slot = hit_idx_reg;
        end
        else if (empty_found_reg)
        begin
            slot = empty_idx_reg;
        end
        else
        begin
            slot = best_idx_reg;
        end
    end

    assign new_cnt = !is_hit ? COUNT_W'(1)
                   : (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                   : hit_cnt_reg + COUNT_W'(1);
    assign wr_data = {page_reg, new_cnt};
    assign mem_we  = (state_reg == ST_WRITE) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                issue_cnt_next = '0;
                if (in_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                end
                if (last_cmp)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fiu_reg        <= FIU_RESET;
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_vld_reg   <= rd_en;
            if (cfg_valid && cfg_ready)
            begin
                fiu_reg <= cfg_data;
            end
            if (mem_we)
            begin
                valid_reg[slot] <= 1'b1;
                if (is_hit)
                begin
                    if (hit_total_reg != TOTAL_MAX)
                    begin
                        hit_total_reg <= hit_total_reg + TOTAL_W'(1);
                    end
                end
                else if (miss_total_reg != TOTAL_MAX)
                begin
                    miss_total_reg <= miss_total_reg + TOTAL_W'(1);
                end
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= issue_cnt_reg[IDX_W-1:0];
        if (in_accept)
        begin
            page_reg        <= in_page;
            n_reg           <= n_next;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            hit_found_reg   <= hit_found_next;
            empty_found_reg <= empty_found_next;
        end
        hit_idx_reg    <= hit_idx_next;
        hit_cnt_reg    <= hit_cnt_next;
        empty_idx_reg  <= empty_idx_next;
        best_cnt_reg   <= best_cnt_next;
        best_idx_reg   <= best_idx_next;
        best_page_reg  <= best_page_next;
        if (mem_we)
        begin
            m_tuser_reg[USER_HIT]   <= is_hit;
            m_tuser_reg[USER_EVICT] <= is_evict;
            m_tdata_reg <= {
                PAD_W'(0),
                is_hit ? miss_total_reg
                    : ((miss_total_reg == TOTAL_MAX) ? miss_total_reg
                        : miss_total_reg + TOTAL_W'(1)),
                !is_hit ? hit_total_reg
                    : ((hit_total_reg == TOTAL_MAX) ? hit_total_reg
                        : hit_total_reg + TOTAL_W'(1)),
                is_evict ? EVICT_W'(best_page_reg) : EVICT_W'(0),
                SLOT_W'(slot)
            };
        end
    end

    `MFU_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_accept, state_reg == ST_SCAN)
    `MFU_ASSERT_NOW(a_hit_no_evict, clk, rst_n, m_tvalid_reg,
        !(m_tuser_reg[USER_HIT] && m_tuser_reg[USER_EVICT]))
    `MFU_ASSERT_NOW(a_cmp_in_range, clk, rst_n, cmp_vld_reg,
        CNT_W'(cmp_idx_reg) < n_reg)
    `MFU_ASSERT_NEXT(a_write_sets_valid, clk, rst_n, mem_we, valid_reg[$past(slot)])

endmodule

FILE: tb/tb_mfu_page_replacement_core.sv
`timescale 1ns / 100ps

import mfu_pkg::*;

typedef struct packed {
    logic               was_hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [EVICT_W-1:0] evicted_page;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
} frame_outcome_t;

class mfu_frame_tracker;
    localparam int FRAMES = 16;

    logic [PAGE_IN_W-1:0] page_of  [FRAMES];
    bit                   resident [FRAMES];
    logic [COUNT_W-1:0]   uses     [FRAMES];
    logic [TOTAL_W-1:0]   hits;
    logic [TOTAL_W-1:0]   misses;
    logic [FIU_W-1:0]     frames_reg;
    frame_outcome_t       outcomes_due[$];
    int                   result_no;
    int                   failures;

    function new();
        frames_reg = FIU_RESET;
        hits       = '0;
        misses     = '0;
        result_no  = 0;
        failures   = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            page_of[i]  = '0;
            resident[i] = 1'b0;
            uses[i]     = '0;
        end
    endfunction

    function void set_frames(logic [FIU_W-1:0] v);
        frames_reg = v;
    endfunction

    // 0 behaves as 1, anything above the frame count as the frame count
    function int active_count();
        if (frames_reg == 0)
            return 1;
        if (frames_reg > FRAMES)
            return FRAMES;
        return int'(frames_reg);
    endfunction

    function frame_outcome_t lookup_and_replace(logic [PAGE_IN_W-1:0] pg);
        frame_outcome_t o;
        int             n;
        int             slot;
        int             i;
        bit             found;
        bit             have_empty;
        logic [COUNT_W-1:0] best;
        o          = '0;
        n          = active_count();
        slot       = 0;
        found      = 1'b0;
        have_empty = 1'b0;
        for (i = 0; i < n && !found; i++)
        begin
            if (resident[i] && page_of[i] == pg)
            begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found)
        begin
            if (uses[slot] != COUNT_MAX)
                uses[slot] = uses[slot] + 1'b1;
            if (hits != TOTAL_MAX)
                hits = hits + 1'b1;
        end
        else
        begin
            for (i = 0; i < n && !have_empty; i++)
            begin
                if (!resident[i])
                begin
                    have_empty = 1'b1;
                    slot       = i;
                end
            end
            if (!have_empty)
            begin
                // highest use count goes, lowest index on a tie
                best = uses[0];
                slot = 0;
                for (i = 1; i < n; i++)
                begin
                    if (uses[i] > best)
                    begin
                        best = uses[i];
                        slot = i;
                    end
                end
                o.evicted_valid = 1'b1;
                o.evicted_page  = page_of[slot];
            end
            page_of[slot]  = pg;
            resident[slot] = 1'b1;
            uses[slot]     = COUNT_W'(1);
            if (misses != TOTAL_MAX)
                misses = misses + 1'b1;
        end
        o.was_hit    = found;
        o.slot       = slot[SLOT_W-1:0];
        o.hit_total  = hits;
        o.miss_total = misses;
        return o;
    endfunction

    function void note_reference(logic [PAGE_IN_W-1:0] pg);
        outcomes_due.push_back(lookup_and_replace(pg));
    endfunction

    function int pending();
        return outcomes_due.size();
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] want,
                                logic [TOTAL_W-1:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= 10)
                $display("result %0d %s: expected 0x%0h, got 0x%0h",
                         result_no, name, want, got);
        end
    endfunction

    function void check_result(frame_outcome_t got);
        frame_outcome_t want;
        result_no++;
        if (outcomes_due.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("result %0d arrived with no reference outstanding", result_no);
            return;
        end
        want = outcomes_due.pop_front();
        compare_field("was_hit", TOTAL_W'(want.was_hit), TOTAL_W'(got.was_hit));
        compare_field("frame_slot", TOTAL_W'(want.slot), TOTAL_W'(got.slot));
        compare_field("evicted_valid", TOTAL_W'(want.evicted_valid),
                      TOTAL_W'(got.evicted_valid));
        compare_field("evicted_page", TOTAL_W'(want.evicted_page),
                      TOTAL_W'(got.evicted_page));
        compare_field("hit_total",     want.hit_total,     got.hit_total);
        compare_field("miss_total",    want.miss_total,    got.miss_total);
    endfunction
endclass

module tb_mfu_page_replacement_core;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 250;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [FIU_W-1:0]        cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [OUT_USER_W-1:0]   m_tuser;

    int                      idle_cycles = 0;
    mfu_frame_tracker        tracker = new();

    mfu_page_replacement_core #(
        .MAX_FRAMES (16),
        .PAGE_BITS  (16)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // handshakes are sampled here; also the no-progress watchdog
    always @(posedge clk)
    begin
        frame_outcome_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_frames(cfg_data);
            if (s_tvalid && s_tready)
                tracker.note_reference(s_tdata[PAGE_IN_W-1:0]);
            if (m_tvalid && m_tready)
            begin
                got.was_hit       = m_tuser[USER_HIT];
                got.evicted_valid = m_tuser[USER_EVICT];
                got.slot          = m_tdata[0 +: SLOT_W];
                got.evicted_page  = m_tdata[SLOT_W +: EVICT_W];
                got.hit_total     = m_tdata[SLOT_W+EVICT_W +: TOTAL_W];
                got.miss_total    = m_tdata[SLOT_W+EVICT_W+TOTAL_W +: TOTAL_W];
                tracker.check_result(got);
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: modes of full speed, coin-flip and mostly stalled
    initial
    begin
        int run;
        int mode;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            run  = $urandom_range(50, 300);
            repeat (run)
            begin
                @(negedge clk);
                if (mode == 0)
                    m_tready <= 1'b1;
                else if (mode == 1)
                    m_tready <= ($urandom_range(0, 1) == 1);
                else
                    m_tready <= ($urandom_range(0, 9) == 0);
            end
        end
    end

    // valid stays up after the item is taken; the next call or a gap decides
    task automatic send_page(input logic [PAGE_IN_W-1:0] pg);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pg;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic hold_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_frames(input logic [FIU_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly pages from a small pool around the active count, so hits and
    // evictions both happen; a share of fully random pages
    task automatic random_phase(input int items);
        int                   pool;
        int                   base;
        int                   hot;
        int                   burst;
        int                   sent;
        logic [PAGE_IN_W-1:0] pg;
        pool = tracker.active_count() + $urandom_range(0, 3);
        base = $urandom_range(0, 65535);
        hot  = $urandom_range(0, pool - 1);
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    pg = PAGE_IN_W'($urandom());
                    2, 3:    pg = PAGE_IN_W'(base + hot);
                    default: pg = PAGE_IN_W'(base + $urandom_range(0, pool - 1));
                endcase
                send_page(pg);
                sent++;
            end
            case ($urandom_range(0, 7))
                4, 5, 6: hold_sender($urandom_range(1, 8));
                7:
                begin
                    if ($urandom_range(0, 3) == 0)
                        drain_results();
                    else
                        hold_sender($urandom_range(10, 40));
                end
                default: ;
            endcase
        end
    endtask

    initial
    begin
        logic [PAGE_IN_W-1:0] fill_pages [12];
        logic [FIU_W-1:0]     phase_frames [8];
        int                   k;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        fill_pages   = '{16'h8000, 16'h0001, 16'h00FF, 16'hFF00, 16'h3C3C, 16'hC3C3,
                         16'h7FFF, 16'h0800, 16'h1000, 16'h2000, 16'h0400, 16'h0002};
        phase_frames = '{5'd16, 5'd17, 5'd1, 5'd8, 5'd0, 5'd31,
                         5'($urandom_range(2, 15)), 5'd3};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset count of four frames: fill, hit, evict on highest count
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h1234);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'h0F0F);   // tie between two frames, lower one goes

        // shrink: the page parked in frame 3 is not seen and lands in frame 0
        write_frames(5'd1);
        send_page(16'hAAAA);
        // grow: same page now in frames 0 and 3, frame 0 takes the hit
        write_frames(5'd4);
        send_page(16'hAAAA);
        send_page(16'h5555);
        write_frames(5'd0);
        send_page(16'h5555);
        write_frames(5'd31);
        for (k = 0; k < 12; k++)
            send_page(fill_pages[k]);

        for (k = 0; k < 8; k++)
        begin
            write_frames(phase_frames[k]);
            random_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
